FILE: hw/rtl/falu_pkg.sv
// Shared types and constants for the Q24.8 fixed-point ALU.
`default_nettype none
package falu_pkg;

    localparam int FRAC_BITS_DEF = 8;
    localparam int WORD_W        = 32;

    typedef enum logic [3:0] {
        OP_ADD      = 4'd0,
        OP_SUB      = 4'd1,
        OP_MUL      = 4'd2,
        OP_DIV      = 4'd3,
        OP_MIN      = 4'd4,
        OP_MAX      = 4'd5,
        OP_INC      = 4'd6,
        OP_DEC      = 4'd7,
        OP_TO_INT   = 4'd8,
        OP_FROM_INT = 4'd9
    } alu_op_t;

endpackage
`default_nettype wire

FILE: hw/rtl/fixed_point_alu_q24_8.sv
// Top level of the pipelined signed fixed-point ALU.
//
// Signed fixed-point ALU on 32-bit raw values with FRAC_BITS fraction bits.
// One item per cycle enters and leaves while neither side stalls; the path is
// input register, operand prep and multiply, 32 + FRAC_BITS restoring
// divider steps, output register. The divider's one-bit-per-stage
// chain sets the depth; every operation travels the same path so results come
// out in order. A two-entry output (register plus skid) lets the pipe keep
// accepting items while a result waits; s_tready drops only once the skid
// entry is full, then the whole pipe holds. Sums wrap, multiply keeps the
// low 32 bits of the 64-bit product shifted right arithmetically, divide
// truncates toward zero and gives 0 with divide_by_zero set for a zero
// divisor. Unused operation codes give 0. Comparison flags are produced for
// every operation.
`default_nettype none
module fixed_point_alu_q24_8
    import falu_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // [31:0] operand_a, [63:32] operand_b
    input  wire logic [3:0]  s_tuser,   // [3:0] operation
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [39:0] m_tdata    // [31:0] result_value, [32] a_less,
                                        // [33] a_equal, [34] a_greater,
                                        // [35] divide_by_zero, [39:36] zero
);

    localparam int DW = WORD_W + FRAC_BITS;

    typedef struct packed {
        alu_op_t           op;
        logic [WORD_W-1:0] res;
        logic              lt;
        logic              eq;
        logic              gt;
        logic              neg;
        logic              dz;
        logic [WORD_W-1:0] dvsr;
        logic [WORD_W-1:0] rem;
        logic [DW-1:0]     work;
    } pipe_t;

    // pipe enable: whole pipe moves unless the skid entry is occupied
    logic en;
    logic skid_full_reg;
    assign en       = !skid_full_reg;
    assign s_tready = en;

    // input register
    logic                     v0_reg;
    alu_op_t                  op0_reg;
    logic signed [WORD_W-1:0] a0_reg;
    logic signed [WORD_W-1:0] b0_reg;

    // operand prep and multiply
    pipe_t                    st1_next;
    logic signed [63:0]       prod_next;
    logic signed [63:0]       prod_reg;
    logic [WORD_W-1:0]        abs_a;
    logic [WORD_W-1:0]        abs_b;

    always_comb begin
        abs_a     = a0_reg[WORD_W-1] ? WORD_W'(-a0_reg) : WORD_W'(a0_reg);
        abs_b     = b0_reg[WORD_W-1] ? WORD_W'(-b0_reg) : WORD_W'(b0_reg);
        prod_next = a0_reg * b0_reg;
        st1_next.op   = op0_reg;
        st1_next.lt   = (a0_reg < b0_reg);
        st1_next.eq   = (a0_reg == b0_reg);
        st1_next.gt   = (a0_reg > b0_reg);
        st1_next.neg  = a0_reg[WORD_W-1] ^ b0_reg[WORD_W-1];
        st1_next.dz   = (op0_reg == OP_DIV) && (b0_reg == '0);
        st1_next.dvsr = abs_b;
        st1_next.rem  = '0;
        st1_next.work = DW'(abs_a) << FRAC_BITS;
        case (op0_reg)
            OP_ADD:      st1_next.res = WORD_W'(a0_reg + b0_reg);
            OP_SUB:      st1_next.res = WORD_W'(a0_reg - b0_reg);
            OP_MIN:      st1_next.res = (a0_reg < b0_reg) ? a0_reg : b0_reg;
            OP_MAX:      st1_next.res = (a0_reg > b0_reg) ? a0_reg : b0_reg;
            OP_INC:      st1_next.res = WORD_W'(a0_reg + 32'sd1);
            OP_DEC:      st1_next.res = WORD_W'(a0_reg - 32'sd1);
            OP_TO_INT:   st1_next.res = WORD_W'(a0_reg >>> FRAC_BITS);
            OP_FROM_INT: st1_next.res = WORD_W'(a0_reg << FRAC_BITS);
            default:     st1_next.res = '0;
        endcase
    end

    // divider stages; stage 0 is the prep result
    pipe_t             st_reg [DW+1];
    pipe_t             st_next [DW+1];
    logic [DW:0]       v_reg;
    logic signed [63:0] prod_sh;

    assign prod_sh    = prod_reg >>> FRAC_BITS;
    assign st_next[0] = st1_next;

    for (genvar k = 1; k <= DW; k++) begin : g_div
        logic [WORD_W-1:0] rem_o;
        logic [DW-1:0]     work_o;

        falu_div_step #(.DW(DW)) u_step (
            .rem_i  (st_reg[k-1].rem),
            .work_i (st_reg[k-1].work),
            .dvsr_i (st_reg[k-1].dvsr),
            .rem_o  (rem_o),
            .work_o (work_o)
        );

        always_comb begin
            st_next[k]      = st_reg[k-1];
            st_next[k].rem  = rem_o;
            st_next[k].work = work_o;
            // product leaves its register one stage after the prep stage
            if (k == 1 && st_reg[0].op == OP_MUL) begin
                st_next[k].res = prod_sh[WORD_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v_reg  <= '0;
        end else if (en) begin
            v0_reg <= s_tvalid;
            v_reg  <= {v_reg[DW-1:0], v0_reg};
        end
        if (en) begin
            op0_reg  <= alu_op_t'(s_tuser[3:0]);
            a0_reg   <= s_tdata[31:0];
            b0_reg   <= s_tdata[63:32];
            prod_reg <= prod_next;
            for (int k = 0; k <= DW; k++) begin
                st_reg[k] <= st_next[k];
            end
        end
    end

    // final result selection
    pipe_t             fin;
    logic [WORD_W-1:0] quo;
    logic [39:0]       fin_data;

    always_comb begin
        fin = st_reg[DW];
        quo = fin.work[WORD_W-1:0];
        if (fin.op == OP_DIV) begin
            fin.res = fin.dz ? '0 : (fin.neg ? WORD_W'(-quo) : quo);
        end
        fin_data = {4'b0000, fin.dz, fin.gt, fin.eq, fin.lt, fin.res};
    end

    // output register plus skid entry
    logic        m_tvalid_reg;
    logic [39:0] m_tdata_reg;
    logic [39:0] skid_reg;
    logic        m_take;
    logic        pipe_out;

    assign m_take   = m_tvalid_reg && m_tready;
    assign pipe_out = en && v_reg[DW];
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg  <= 1'b0;
            skid_full_reg <= 1'b0;
        end else if (skid_full_reg) begin
            if (m_take) begin
                m_tdata_reg   <= skid_reg;
                skid_full_reg <= 1'b0;
            end
        end else if (!m_tvalid_reg || m_take) begin
            m_tvalid_reg <= pipe_out;
            if (pipe_out) begin
                m_tdata_reg <= fin_data;
            end
        end else if (pipe_out) begin
            skid_reg      <= fin_data;
            skid_full_reg <= 1'b1;
        end
    end

    a_skid_needs_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_full_reg |-> m_tvalid_reg)
        else $error("skid entry held while output register empty");

    a_flags_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> $onehot(m_tdata_reg[34:32]))
        else $error("comparison flags not one-hot");

    a_dz_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && m_tdata_reg[35]) |-> (m_tdata_reg[31:0] == '0))
        else $error("divide by zero with nonzero result");

    a_skid_holds_pipe: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_full_reg |=> $stable(v_reg) || !skid_full_reg || $past(m_take))
        else $error("pipe moved while skid entry full");

endmodule
`default_nettype wire

FILE: hw/rtl/falu_div_step.sv
// One restoring-division step: brings in one dividend bit, yields one quotient bit.
`default_nettype none
module falu_div_step
    import falu_pkg::*;
#(
    parameter int DW = WORD_W + FRAC_BITS_DEF
) (
    input  wire logic [WORD_W-1:0] rem_i,
    input  wire logic [DW-1:0]     work_i,
    input  wire logic [WORD_W-1:0] dvsr_i,
    output logic      [WORD_W-1:0] rem_o,
    output logic      [DW-1:0]     work_o
);

    logic [WORD_W:0] trial;
    logic [WORD_W:0] diff;
    logic            q_bit;

    // work holds remaining dividend bits on top, quotient bits shift in below
    always_comb begin
        trial  = {rem_i, work_i[DW-1]};
        diff   = trial - {1'b0, dvsr_i};
        q_bit  = (trial >= {1'b0, dvsr_i});
        rem_o  = q_bit ? diff[WORD_W-1:0] : trial[WORD_W-1:0];
        work_o = {work_i[DW-2:0], q_bit};
    end

endmodule
`default_nettype wire

FILE: tb/tb_fixed_point_alu_q24_8.sv
// Testbench for the Q24.8 fixed-point ALU: random and directed items checked against a predictor.
`default_nettype none
module tb_fixed_point_alu_q24_8;
    import falu_pkg::*;

    localparam int FB      = FRAC_BITS_DEF;
    localparam int LATENCY = FB + 35;
    localparam int N_RAND  = 1400;
    localparam longint CYCLE_LIMIT = 400000;

    // one input item as the driver sees it
    typedef struct packed {
        logic [3:0]  op;
        logic [31:0] a;
        logic [31:0] b;
    } alu_item_t;

    // one result item, field order matches m_tdata from the top
    typedef struct packed {
        logic        dz;
        logic        gt;
        logic        eq;
        logic        lt;
        logic [31:0] value;
    } alu_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic [3:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;

    alu_item_t   pending_items[$];
    alu_result_t expected_results[$];
    int          mismatch_count = 0;
    int          results_seen = 0;
    int          items_sent = 0;
    longint      cycle_count = 0;
    int          hold_off = 0;      // long receiver stall, counted down by its own process
    int          drv_gap = 0;
    int          rcv_gap = 0;
    int          op_hits[16];

    fixed_point_alu_q24_8 #(.FRAC_BITS(FB)) uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always #6 aclk = ~aclk;

    // Behavior of the ALU for one item.
    function automatic alu_result_t alu_predict(alu_item_t it);
        alu_result_t r;
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic signed [63:0] prod;
        logic signed [63:0] num;
        a = it.a;
        b = it.b;
        r = '0;
        r.lt = a < b;
        r.eq = a == b;
        r.gt = a > b;
        case (it.op)
            OP_ADD:      r.value = a + b;
            OP_SUB:      r.value = a - b;
            OP_MUL: begin
                prod = 64'(a) * 64'(b);
                prod = prod >>> FB;
                r.value = prod[31:0];
            end
            OP_DIV: begin
                if (b == 0) begin
                    r.dz = 1'b1;
                end else begin
                    num = 64'(a) <<< FB;
                    num = num / 64'(b);    // SV signed divide truncates toward zero
                    r.value = num[31:0];
                end
            end
            OP_MIN:      r.value = (a < b) ? a : b;
            OP_MAX:      r.value = (a > b) ? a : b;
            OP_INC:      r.value = a + 32'sd1;
            OP_DEC:      r.value = a - 32'sd1;
            OP_TO_INT:   r.value = a >>> FB;
            OP_FROM_INT: r.value = a << FB;
            default:     r.value = '0;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH result %0d %s: got %h want %h", results_seen, what, got, want);
        mismatch_count++;
    endtask

    function automatic logic [31:0] rand_operand();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'($urandom_range(0, 2000)) - 32'd1000;
            3: return 32'h0;
            4: return 32'($urandom_range(0, 1 << 16)) << FB;
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_item(input logic [3:0] op, input logic [31:0] a, input logic [31:0] b);
        alu_item_t it;
        it.op = op;
        it.a  = a;
        it.b  = b;
        pending_items.push_back(it);
    endtask

    // Driver: pops pending items, random gaps, keeps tvalid high across back-to-back items.
    always @(posedge aclk) begin
        alu_item_t nxt;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                expected_results.push_back(alu_predict({s_tuser, s_tdata[31:0], s_tdata[63:32]}));
                items_sent++;
                op_hits[s_tuser]++;
            end
            if (!s_tvalid || s_tready) begin
                if (drv_gap > 0) begin
                    drv_gap <= drv_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    nxt = pending_items.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= nxt.op;
                    s_tdata  <= {nxt.b, nxt.a};
                    if ($urandom_range(0, 3) == 0)
                        drv_gap <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                              : $urandom_range(1, 3);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each accepted result against the oldest expectation.
    always @(posedge aclk) begin
        alu_result_t got;
        alu_result_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got = m_tdata[35:0];
                results_seen++;
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected item", got.value, 32'h0);
                end else begin
                    want = expected_results.pop_front();
                    if (got.value !== want.value) report_mismatch("result_value", got.value, want.value);
                    if (got.lt !== want.lt) report_mismatch("a_less", 32'(got.lt), 32'(want.lt));
                    if (got.eq !== want.eq) report_mismatch("a_equal", 32'(got.eq), 32'(want.eq));
                    if (got.gt !== want.gt) report_mismatch("a_greater", 32'(got.gt), 32'(want.gt));
                    if (got.dz !== want.dz)
                        report_mismatch("divide_by_zero", 32'(got.dz), 32'(want.dz));
                    if (m_tdata[39:36] !== 4'h0) report_mismatch("pad bits", 32'(m_tdata[39:36]), 32'h0);
                end
            end
            // receiver readiness: long hold-off wins, then random stalls
            if (hold_off > 0) begin
                m_tready <= 1'b0;
            end else if (rcv_gap > 0) begin
                rcv_gap <= rcv_gap - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 4) == 0)
                    rcv_gap <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
                                                          : $urandom_range(1, 3);
            end
        end
    end

    // Long receiver stall so the pipe fills and s_tready drops.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (hold_off > 0)
                hold_off <= hold_off - 1;
            else if (items_sent == 300)
                hold_off <= 3 * LATENCY;
        end
    end

    // Watchdog.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("fixed_point_alu_q24_8 test failed");
            $finish;
        end
    end

    initial begin
        logic [31:0] edge_vals[6];
        edge_vals = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff, 32'h0000_0100,
                      32'hffff_ff00};
        for (int i = 0; i < 16; i++) op_hits[i] = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: every operation on extremes, divide by zero, unused codes
        for (int op = 0; op < 10; op++)
            queue_item(4'(op), edge_vals[op % 6], edge_vals[(op + 1) % 6]);
        queue_item(OP_DIV, 32'h0000_1234, 32'h0);
        queue_item(OP_DIV, 32'h8000_0000, 32'hffff_ffff);     // quotient overflows 32 bits
        queue_item(OP_DIV, 32'hffff_fd00, 32'h0000_0200);     // negative quotient, exactly -1.5
        queue_item(OP_MUL, 32'h8000_0000, 32'h8000_0000);
        queue_item(OP_MIN, 32'h1234_5678, 32'h1234_5678);     // equal operands
        queue_item(OP_MAX, 32'h8000_0000, 32'h7fff_ffff);
        queue_item(OP_INC, 32'h7fff_ffff, 32'h0);
        queue_item(OP_DEC, 32'h8000_0000, 32'h0);
        queue_item(OP_TO_INT, 32'hffff_ff01, 32'h0);
        queue_item(OP_FROM_INT, 32'h7fff_ffff, 32'h0);
        queue_item(4'd10, 32'hffff_ffff, 32'h0);
        queue_item(4'd15, 32'h0000_0001, 32'hffff_ffff);

        // random part
        for (int i = 0; i < N_RAND; i++)
            queue_item(($urandom_range(0, 19) == 0) ? 4'($urandom_range(10, 15))
                                                    : 4'($urandom_range(0, 9)),
                       rand_operand(), ($urandom_range(0, 3) == 0) ? rand_operand() : $urandom);

        wait (pending_items.size() == 0 && !s_tvalid);
        wait (expected_results.size() == 0);
        repeat (LATENCY + 10) @(posedge aclk);

        $display("sent %0d items, checked %0d results; long output stall applied once",
                 items_sent, results_seen);
        $display("ops add..from_int hits: %0d %0d %0d %0d %0d %0d %0d %0d %0d %0d",
                 op_hits[0], op_hits[1], op_hits[2], op_hits[3], op_hits[4],
                 op_hits[5], op_hits[6], op_hits[7], op_hits[8], op_hits[9]);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("fixed_point_alu_q24_8 test passed");
        end else begin
            $display("fixed_point_alu_q24_8 test failed");
        end
        $finish;
    end
endmodule
`default_nettype wire

FILE: sim.f
hw/rtl/falu_pkg.sv
hw/rtl/falu_div_step.sv
hw/rtl/fixed_point_alu_q24_8.sv
tb/tb_fixed_point_alu_q24_8.sv
